FILE: design/esf_pkg.sv
// ----------------------------------------------------------------------------
// esf_pkg
// Types, constants and the CORDIC angle table for the Ewald structure
// factor engine.
// ----------------------------------------------------------------------------
package esf_pkg;

  localparam int unsigned MaxEntriesDef = 2048;
  localparam int unsigned PhaseBitsDef  = 16;
  localparam int unsigned CordicSteps   = 20;

  localparam logic [33:0] CordicGain = 34'd652032875;
  localparam logic [62:0] EnergySat  = {63{1'b1}};

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_MOVE  = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ENTRY_COUNT = 2'd0,
    REG_INV_LEN_X   = 2'd1,
    REG_INV_LEN_Y   = 2'd2,
    REG_INV_LEN_Z   = 2'd3
  } cfg_reg_e;

  // Result status codes
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PRE,
    ST_RD,
    ST_WAIT,
    ST_PH,
    ST_CINIT,
    ST_CORD,
    ST_ACC,
    ST_WB,
    ST_EN,
    ST_DONE
  } state_e;

  // CORDIC rotation angles in turns, 2^32 per full turn
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004755;
      5'd4:    a = 32'd42667332;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/ewald_structure_factor_engine.sv
// ----------------------------------------------------------------------------
// ewald_structure_factor_engine
// Reciprocal-space structure factor table with charge add/move updates and
// a weighted |S|^2 energy query, swept one entry at a time out of memory.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  s_axis   | s_axis_tvalid/tready       | tuser req_type, tdata request
//  m_axis   | m_axis_tvalid/tready       | tuser status, tdata energy_sum
//  cfg      | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
//
// Add, move and query requests sweep n = min(entry_count, MAX_ENTRIES)
// entries; the per-entry cost of add and move is set by the iterative
// CORDIC and by the single-port read-modify-write of the sum memory. One
// request is in flight at a time; a finished result waits in the output
// register and a stalled output holds the sequencer in its last state.
// Reset clears control and configuration only; the memories need no
// clearing pass.
// ----------------------------------------------------------------------------
module ewald_structure_factor_engine
  import esf_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned PHASE_BITS  = PhaseBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: entry_index, wave_nx, wave_ny, wave_nz, damping_weight, charge,
  //        new_pos_x, new_pos_y, new_pos_z, old_pos_x, old_pos_yz, zero pad
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [271:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // tuser: req_type
  // tdata: energy_sum, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,
  output logic         m_axis_tuser,   // tuser: status
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = AW + 1;

  // Configuration registers
  logic [11:0] entry_count_q;
  logic [31:0] inv_x_q, inv_y_q, inv_z_q;

  state_e state_q, state_d;

  // Latched request
  req_e        req_q;
  logic [10:0] idx_q;
  logic [17:0] wave_in_q;
  logic [31:0] weight_in_q;
  logic signed [15:0] charge_q;
  logic [31:0] pos_q [6];
  logic [CW-1:0] n_q, k_q;
  logic [2:0]  j_q;
  logic        pass_q;
  logic [47:0] prod_q [6];

  // Memories and their read registers
  logic [49:0] wave_mem [MAX_ENTRIES];
  logic [95:0] sum_mem  [MAX_ENTRIES];
  logic [49:0] wrd_q;
  logic [95:0] srd_q;

  // Entry working registers
  logic [47:0] sr_q, si_q, acc_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [4:0]  it_q;
  logic [1:0]  quad_q;
  logic [63:0] mr_q, m_q, ph_q, lo_q;
  logic [62:0] en_q;

  // Result register
  logic        out_valid_q;
  logic [62:0] out_energy_q;
  logic        out_status_q;

  // Strobes from the sequencer
  logic wave_we, sum_we, mem_re, out_load, accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Index range checks and sweep length
  logic [16:0]  cnt_ext;
  logic         in_range;
  logic [AW-1:0] idx_addr, k_addr;
  logic [CW-1:0] n_in;
  assign cnt_ext  = 17'(entry_count_q);
  assign n_in     = (cnt_ext > 17'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cnt_ext);
  assign in_range = 17'(idx_q) < 17'(MAX_ENTRIES);
  logic [16:0] idx_q_ext;
  assign idx_q_ext = 17'(idx_q);
  assign idx_addr  = idx_q_ext[AW-1:0];
  assign k_addr    = k_q[AW-1:0];

  // Position times reciprocal length, kept modulo 2^48
  logic [31:0] pre_pos, pre_inv;
  logic signed [65:0] pre_prod;
  always_comb begin
    pre_pos = pos_q[j_q];
    case (j_q)
      3'd0, 3'd3: pre_inv = inv_x_q;
      3'd1, 3'd4: pre_inv = inv_y_q;
      default:    pre_inv = inv_z_q;
    endcase
  end
  assign pre_prod = $signed({pre_pos[31], pre_pos}) * $signed({1'b0, pre_inv});

  // Phase term: wavenumber times the matching product
  logic [2:0]  psel_idx;
  logic signed [5:0] nsel;
  logic signed [53:0] term_full;
  always_comb begin
    psel_idx = pass_q ? j_q : j_q + 3'd3;
    case (j_q)
      3'd0:    nsel = $signed(wrd_q[49:44]);
      3'd1:    nsel = $signed(wrd_q[43:38]);
      default: nsel = $signed(wrd_q[37:32]);
    endcase
  end
  assign term_full = $signed(prod_q[psel_idx]) * nsel;

  // CORDIC setup
  logic [PHASE_BITS-1:0] phase;
  logic [31:0] ang;
  assign phase = acc_q[47 -: PHASE_BITS];
  assign ang   = 32'(phase) << (32 - PHASE_BITS);

  // CORDIC step
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;
  assign dx = cy_q >>> it_q;
  assign dy = cx_q >>> it_q;
  assign at = $signed({1'b0, atan_turns(it_q)});

  // Round, rotate by quadrant, scale by the charge
  logic signed [33:0] rx, ry;
  logic signed [17:0] cr, sr, cv, sv;
  logic signed [33:0] tr, ti;
  assign rx = (cx_q + 34'sd8192) >>> 14;
  assign ry = (cy_q + 34'sd8192) >>> 14;
  assign cr = rx[17:0];
  assign sr = ry[17:0];
  always_comb begin
    case (quad_q)
      2'd0:    begin cv = cr;  sv = sr;  end
      2'd1:    begin cv = -sr; sv = cr;  end
      2'd2:    begin cv = -cr; sv = -sr; end
      default: begin cv = sr;  sv = -cr; end
    endcase
  end
  assign tr = charge_q * cv;
  assign ti = charge_q * sv;

  // Energy datapath
  logic signed [31:0] er, ei;
  logic signed [63:0] sq;
  logic [63:0] t_raw, t_sum;
  logic [62:0] t_sat;
  assign er = $signed(sr_q[47:16]);
  assign ei = $signed(si_q[47:16]);
  assign sq = (j_q == 3'd0) ? er * er : ei * ei;
  assign t_raw = (ph_q[63:55] != 9'd0) ? 64'(EnergySat)
               : ((ph_q << 8) + (lo_q >> 24));
  assign t_sat = (t_raw > 64'(EnergySat)) ? EnergySat : t_raw[62:0];
  assign t_sum = 64'(en_q) + 64'(t_sat);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      inv_x_q       <= '0;
      inv_y_q       <= '0;
      inv_z_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ENTRY_COUNT: entry_count_q <= cfg_wdata_i[11:0];
        REG_INV_LEN_X:   inv_x_q       <= cfg_wdata_i;
        REG_INV_LEN_Y:   inv_y_q       <= cfg_wdata_i;
        REG_INV_LEN_Z:   inv_z_q       <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_e'(s_axis_tuser))
            REQ_WRITE: state_d = ST_WRITE;
            REQ_QUERY: state_d = (n_in == '0) ? ST_DONE : ST_RD;
            default:   state_d = ST_PRE;
          endcase
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_PRE:   if (j_q == 3'd5) state_d = (n_q == '0) ? ST_DONE : ST_RD;
      ST_RD:    state_d = ST_WAIT;
      ST_WAIT:  state_d = (req_q == REQ_QUERY) ? ST_EN : ST_PH;
      ST_PH:    if (j_q == 3'd2) state_d = ST_CINIT;
      ST_CINIT: state_d = ST_CORD;
      ST_CORD:  if (it_q == 5'(CordicSteps - 1)) state_d = ST_ACC;
      ST_ACC:   state_d = pass_q ? ST_WB : ST_PH;
      ST_WB:    state_d = (k_q + 1'b1 == n_q) ? ST_DONE : ST_RD;
      ST_EN:    if (j_q == 3'd4) state_d = (k_q + 1'b1 == n_q) ? ST_DONE : ST_RD;
      ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer strobes
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    wave_we       = (state_q == ST_WRITE) && in_range;
    sum_we        = wave_we || (state_q == ST_WB);
    mem_re        = (state_q == ST_RD);
    out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wave_we) wave_mem[idx_addr] <= {wave_in_q, weight_in_q};
    if (mem_re)  wrd_q <= wave_mem[k_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[wave_we ? idx_addr : k_addr] <= wave_we ? 96'd0 : {sr_q, si_q};
    if (mem_re) srd_q <= sum_mem[k_addr];
  end

  // Sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      j_q    <= '0;
      pass_q <= 1'b0;
      it_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          j_q <= '0;
        end
        ST_PRE:  j_q <= (j_q == 3'd5) ? 3'd0 : j_q + 3'd1;
        ST_WAIT: begin
          j_q    <= '0;
          pass_q <= (req_q != REQ_MOVE);
        end
        ST_PH:   j_q <= (j_q == 3'd2) ? 3'd0 : j_q + 3'd1;
        ST_CINIT: it_q <= '0;
        ST_CORD: it_q <= it_q + 5'd1;
        ST_ACC:  pass_q <= 1'b1;
        ST_WB:   k_q <= k_q + 1'b1;
        ST_EN: begin
          j_q <= (j_q == 3'd4) ? 3'd0 : j_q + 3'd1;
          if (j_q == 3'd4) k_q <= k_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Request capture and entry datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= req_e'(s_axis_tuser);
      idx_q       <= s_axis_tdata[10:0];
      wave_in_q   <= {s_axis_tdata[16:11], s_axis_tdata[22:17], s_axis_tdata[28:23]};
      weight_in_q <= s_axis_tdata[60:29];
      charge_q    <= $signed(s_axis_tdata[76:61]);
      pos_q[0]    <= s_axis_tdata[108:77];
      pos_q[1]    <= s_axis_tdata[140:109];
      pos_q[2]    <= s_axis_tdata[172:141];
      pos_q[3]    <= s_axis_tdata[204:173];
      pos_q[4]    <= s_axis_tdata[268:237];
      pos_q[5]    <= s_axis_tdata[236:205];
      n_q         <= n_in;
      en_q        <= '0;
    end
    case (state_q)
      ST_PRE:  prod_q[j_q] <= pre_prod[47:0];
      ST_WAIT: begin
        sr_q <= srd_q[95:48];
        si_q <= srd_q[47:0];
      end
      ST_PH:   acc_q <= ((j_q == 3'd0) ? 48'd0 : acc_q) + term_full[47:0];
      ST_CINIT: begin
        cx_q   <= $signed(CordicGain);
        cy_q   <= '0;
        cz_q   <= $signed({3'b000, ang[29:0]});
        quad_q <= ang[31:30];
      end
      ST_CORD: begin
        if (!cz_q[32]) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + at;
        end
      end
      ST_ACC: begin
        if (pass_q) begin
          sr_q <= sr_q + 48'(tr);
          si_q <= si_q + 48'(ti);
        end else begin
          sr_q <= sr_q - 48'(tr);
          si_q <= si_q - 48'(ti);
        end
      end
      ST_EN: begin
        case (j_q)
          3'd0:    mr_q <= sq;
          3'd1:    m_q  <= mr_q + sq;
          3'd2:    ph_q <= 64'(m_q[63:32]) * 64'(wrd_q[31:0]);
          3'd3:    lo_q <= 64'(m_q[31:0]) * 64'(wrd_q[31:0]);
          default: en_q <= (t_sum > 64'(EnergySat)) ? EnergySat : t_sum[62:0];
        endcase
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_energy_q <= (req_q == REQ_QUERY) ? en_q : 63'd0;
      out_status_q <= (req_q == REQ_WRITE && !in_range) ? STATUS_RANGE : STATUS_DONE;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_energy_q};
  assign m_axis_tuser  = out_status_q;

  // Checks
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (k_q < n_q))
    else $error("sweep index past the active entry count");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  a_range_no_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("range error result carries energy");

endmodule

FILE: tb/sv/tb_ewald_structure_factor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ewald_structure_factor_engine
// Drives write, add, move and query requests into the structure factor
// engine under several register settings and handshake idling mixes. A
// predictor built from the same fixed-point rules checks every result.
// ----------------------------------------------------------------------------
module tb_ewald_structure_factor_engine;
  import esf_pkg::*;

  localparam int unsigned TableDepth = 2048;
  localparam longint unsigned CycleLimit = 4000000;
  localparam logic [63:0] EnergyCap = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint AngleTurns [20] = '{
    536870912, 316933406, 167458907, 85004755, 42667332, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304};

  typedef struct {
    req_e        kind;
    logic [10:0] idx;
    logic [5:0]  nx, ny, nz;
    logic [31:0] weight;
    logic [15:0] q;
    logic [31:0] px, py, pz, ox;
    logic [63:0] oyz;
  } esf_req_t;

  typedef struct {
    logic [62:0] energy;
    logic        status;
  } esf_result_t;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [271:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we_i;
  logic [1:0]   cfg_addr_i;
  logic [31:0]  cfg_wdata_i;

  ewald_structure_factor_engine dut (.*);

  // Predictor state
  logic [11:0] count_reg;
  logic [31:0] inv_len [3];
  logic [17:0] wave_tab [TableDepth];
  logic [31:0] weight_tab [TableDepth];
  logic [47:0] sum_re [TableDepth];
  logic [47:0] sum_im [TableDepth];

  esf_result_t pending_results[$];
  int          error_count;
  int          send_idle_pct, recv_stall_pct;
  bit          hold_active;
  longint unsigned cycle_count;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_ewald_structure_factor_engine failed");
      $finish;
    end
  end

  // Receiver: random stalls, forced low during a hold-off
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [15:0] phase_turns(logic [17:0] wn, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z);
    logic [63:0] nx, ny, nz, acc;
    nx = {{58{wn[17]}}, wn[17:12]};
    ny = {{58{wn[11]}}, wn[11:6]};
    nz = {{58{wn[5]}}, wn[5:0]};
    acc = nx * ({{32{x[31]}}, x} * {32'd0, inv_len[0]})
        + ny * ({{32{y[31]}}, y} * {32'd0, inv_len[1]})
        + nz * ({{32{z[31]}}, z} * {32'd0, inv_len[2]});
    return acc[47:32];
  endfunction

  function automatic void cordic_sincos(logic [15:0] ph, output longint c,
                                        output longint s);
    logic [31:0] ang;
    longint x, y, z, dx, dy, cr, sr;
    ang = {ph, 16'd0};
    x = 652032875;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AngleTurns[i];
      end else begin
        x += dx; y -= dy; z += AngleTurns[i];
      end
    end
    cr = (x + 8192) >>> 14;
    sr = (y + 8192) >>> 14;
    case (ang[31:30])
      2'd0:    begin c = cr;  s = sr;  end
      2'd1:    begin c = -sr; s = cr;  end
      2'd2:    begin c = -cr; s = -sr; end
      default: begin c = sr;  s = -cr; end
    endcase
  endfunction

  function automatic void apply_charge(int k, logic [15:0] q, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] z, bit negate);
    longint c, s, tr, ti;
    cordic_sincos(phase_turns(wave_tab[k], x, y, z), c, s);
    tr = longint'($signed(q)) * c;
    ti = longint'($signed(q)) * s;
    if (negate) begin
      tr = -tr; ti = -ti;
    end
    sum_re[k] = sum_re[k] + tr[47:0];
    sum_im[k] = sum_im[k] + ti[47:0];
  endfunction

  function automatic logic [63:0] entry_energy(int k);
    longint r, i;
    logic [63:0] m, w, ph, t;
    r = longint'($signed(sum_re[k])) >>> 16;
    i = longint'($signed(sum_im[k])) >>> 16;
    m = r * r + i * i;
    w = {32'd0, weight_tab[k]};
    ph = {32'd0, m[63:32]} * w;
    if (ph >= 64'h0080_0000_0000_0000) return EnergyCap;
    t = (ph << 8) + (({32'd0, m[31:0]} * w) >> 24);
    return (t > EnergyCap) ? EnergyCap : t;
  endfunction

  // Update the predictor for one accepted request and queue its result
  function automatic void predict_request(esf_req_t r);
    esf_result_t res;
    int n;
    logic [63:0] e, t;
    n = (count_reg > TableDepth) ? TableDepth : int'(count_reg);
    e = 0;
    res.status = STATUS_DONE;
    case (r.kind)
      REQ_WRITE: begin
        if (r.idx >= TableDepth) begin
          res.status = STATUS_RANGE;
        end else begin
          wave_tab[r.idx] = {r.nx, r.ny, r.nz};
          weight_tab[r.idx] = r.weight;
          sum_re[r.idx] = '0;
          sum_im[r.idx] = '0;
        end
      end
      REQ_ADD, REQ_MOVE: begin
        for (int k = 0; k < n; k++) begin
          if (r.kind == REQ_MOVE) apply_charge(k, r.q, r.ox, r.oyz[63:32], r.oyz[31:0], 1);
          apply_charge(k, r.q, r.px, r.py, r.pz, 0);
        end
      end
      default: begin
        for (int k = 0; k < n; k++) begin
          t = entry_energy(k);
          e = (t > EnergyCap - e) ? EnergyCap : e + t;
        end
      end
    endcase
    res.energy = e[62:0];
    pending_results = {pending_results, res};
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    esf_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[62:0] !== want.energy)
          report_mismatch("energy_sum", {1'b0, m_axis_tdata[62:0]}, {1'b0, want.energy});
        if (m_axis_tuser !== want.status)
          report_mismatch("status", {63'd0, m_axis_tuser}, {63'd0, want.status});
      end
    end
  end

  // ------------------------------------------------------------------- driver
  task automatic send_request(esf_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = r.kind;
    s_axis_tdata = {3'd0, r.oyz, r.ox, r.pz, r.py, r.px, r.q, r.weight,
                    r.nz, r.ny, r.nx, r.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(r);
  endtask

  // Let the block drain, then go quiet before touching registers
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e a, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = a;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (a)
      REG_ENTRY_COUNT: count_reg = v[11:0];
      REG_INV_LEN_X:   inv_len[0] = v;
      REG_INV_LEN_Y:   inv_len[1] = v;
      default:         inv_len[2] = v;
    endcase
  endtask

  task automatic set_box(logic [11:0] n, logic [31:0] ix, logic [31:0] iy,
                         logic [31:0] iz);
    write_reg(REG_ENTRY_COUNT, {20'd0, n});
    write_reg(REG_INV_LEN_X, ix);
    write_reg(REG_INV_LEN_Y, iy);
    write_reg(REG_INV_LEN_Z, iz);
  endtask

  function automatic esf_req_t random_request(req_e kind, bit low_index);
    esf_req_t r;
    r.kind = kind;
    r.idx = low_index ? 11'($urandom_range(15)) : 11'($urandom);
    r.nx = 6'($urandom); r.ny = 6'($urandom); r.nz = 6'($urandom);
    r.weight = $urandom_range(1) ? $urandom : $urandom_range(1 << 20);
    r.q = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023) - 512);
    r.px = $urandom; r.py = $urandom; r.pz = $urandom; r.ox = $urandom;
    r.oyz = {$urandom, $urandom};
    return r;
  endfunction

  // ------------------------------------------------------------------- tests
  // Fill entries 0..15, the first two with extreme wave vectors and weights,
  // then one of each kind, including sweeps over no entries at all
  task automatic test_directed();
    esf_req_t r;
    set_box(12'd0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    for (int k = 0; k < 16; k++) begin
      r = random_request(REQ_WRITE, 1);
      r.idx = 11'(k);
      if (k == 0) begin r.nx = 6'h20; r.ny = 6'h1F; r.nz = 6'h00; r.weight = 32'hFFFF_FFFF; end
      if (k == 1) begin r.nx = 6'h1F; r.ny = 6'h20; r.nz = 6'h3F; r.weight = 32'h0; end
      send_request(r);
    end
    r = random_request(REQ_ADD, 1);
    send_request(r);
    r.kind = REQ_QUERY;
    send_request(r);
    wait_drained();
    write_reg(REG_ENTRY_COUNT, 32'd4);
    r = random_request(REQ_ADD, 1);
    r.q = 16'h7FFF; r.px = 32'h7FFF_FFFF; r.py = 32'h8000_0000; r.pz = 32'h0;
    send_request(r);
    r.kind = REQ_MOVE; r.q = 16'h8000;
    r.ox = 32'h8000_0000; r.oyz = 64'h7FFF_FFFF_0000_0000;
    send_request(r);
    r.kind = REQ_QUERY;
    send_request(r);
    r = random_request(REQ_WRITE, 0);
    r.idx = 11'h7FF;
    send_request(r);
    r.kind = REQ_QUERY;
    send_request(r);
    wait_drained();
  endtask

  // Mostly updates and queries over the written prefix, some far writes
  task automatic test_random(int items, int idle_pct, int stall_pct);
    esf_req_t r;
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    set_box(12'($urandom_range(16, 1)), $urandom, $urandom, $urandom);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) r = random_request(REQ_WRITE, $urandom_range(3) != 0);
      else if (pick < 50) r = random_request(REQ_ADD, 1);
      else if (pick < 75) r = random_request(REQ_MOVE, 1);
      else r = random_request(REQ_QUERY, 1);
      send_request(r);
    end
    wait_drained();
  endtask

  // Hold the output off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_active = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_active = 1'b0;
      end
    join_none
    for (int i = 0; i < 8; i++) send_request(random_request(REQ_ADD, 1));
    send_request(random_request(REQ_QUERY, 1));
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    hold_active = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    count_reg = '0;
    inv_len = '{default: '0};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_WRITE;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_ENTRY_COUNT;
    cfg_wdata_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(65, 0, 0);
    test_random(65, 76, 0);
    test_random(65, 0, 76);
    test_random(65, 32, 32);
    test_backpressure();

    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_ewald_structure_factor_engine passed");
    end else begin
      $display("tb_ewald_structure_factor_engine failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/esf_pkg.sv
design/ewald_structure_factor_engine.sv
tb/sv/tb_ewald_structure_factor_engine.sv
